// File: src/mi_pkg.sv
// package for the modular inverse unit: operand width, word types
`timescale 1ns / 1ps

package mi_pkg;

    // width of the arithmetic datapath; operands use the low WIDTH bits of each field
    localparam int WIDTH = 32;
    // bits of the quotient bit position counter
    localparam int KW = $clog2(WIDTH);

    typedef struct packed {
        logic [31:0] value;
        logic [31:0] modulus;
    } mi_in_t;

    typedef struct packed {
        logic [31:0] inverse;
        logic [31:0] divisor;
        logic        invertible;
    } mi_out_t;

endpackage

// File: src/mi_euclid_core.sv
// extended euclid sequencer around one shared subtract/add unit
`timescale 1ns / 1ps

module mi_euclid_core
    import mi_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    start,
    input  mi_in_t  in_word,
    output logic    idle,
    output logic    done,
    input  logic    take,
    output mi_out_t res_word
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_NEXT  = 3'd1;
    localparam logic [2:0] ST_ALIGN = 3'd2;
    localparam logic [2:0] ST_SUB   = 3'd3;
    localparam logic [2:0] ST_RED   = 3'd4;
    localparam logic [2:0] ST_INV   = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [WIDTH-1:0] m_reg;
    logic [WIDTH-1:0] r_old_reg, r_cur_reg;
    logic [WIDTH-1:0] s_old_reg, s_cur_reg;
    logic [WIDTH-1:0] d_reg, sd_reg;
    logic [KW-1:0]    k_reg;
    logic             odd_reg;
    logic             ok_reg;
    mi_out_t          res_reg;

    // shared unit: one wide subtract (doubles as compare) and one add
    logic [WIDTH:0]   diff;
    logic             ge;
    logic [WIDTH-1:0] rem_n;
    logic [WIDTH-1:0] acc_n;
    logic             can_shift;
    logic [WIDTH-1:0] red_diff;
    logic [WIDTH-1:0] inv_val;

    always_comb begin
        diff      = {1'b0, r_old_reg} - {1'b0, d_reg};
        ge        = ~diff[WIDTH];
        rem_n     = ge ? diff[WIDTH-1:0] : r_old_reg;
        acc_n     = ge ? (s_old_reg + sd_reg) : s_old_reg;
        // divisor may still double without passing the dividend
        can_shift = ~d_reg[WIDTH-1] && ({d_reg, 1'b0} <= {1'b0, r_old_reg});
        red_diff  = s_old_reg - m_reg;
        inv_val   = (odd_reg && (s_old_reg != '0)) ? red_diff : s_old_reg;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (start) state_next = ST_NEXT;
            ST_NEXT:  state_next = (r_cur_reg == '0) ? ST_RED : ST_ALIGN;
            ST_ALIGN: if (!can_shift) state_next = ST_SUB;
            ST_SUB:   if (k_reg == '0) state_next = ST_NEXT;
            ST_RED:   state_next = ST_INV;
            ST_INV:   state_next = ST_DONE;
            ST_DONE:  if (take) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                m_reg     <= WIDTH'(in_word.modulus);
                r_old_reg <= WIDTH'(in_word.value);
                r_cur_reg <= WIDTH'(in_word.modulus);
                s_old_reg <= WIDTH'(1);
                s_cur_reg <= '0;
                odd_reg   <= 1'b0;
            end
            ST_NEXT: begin
                d_reg  <= r_cur_reg;
                sd_reg <= s_cur_reg;
                k_reg  <= '0;
            end
            ST_ALIGN: begin
                if (can_shift) begin
                    d_reg  <= {d_reg[WIDTH-2:0], 1'b0};
                    sd_reg <= {sd_reg[WIDTH-2:0], 1'b0};
                    k_reg  <= k_reg + KW'(1);
                end
            end
            ST_SUB: begin
                if (k_reg == '0) begin
                    // last quotient bit: rotate the remainder and coefficient pairs
                    r_old_reg <= r_cur_reg;
                    r_cur_reg <= rem_n;
                    s_old_reg <= s_cur_reg;
                    s_cur_reg <= acc_n;
                    odd_reg   <= ~odd_reg;
                end else begin
                    r_old_reg <= rem_n;
                    s_old_reg <= acc_n;
                    d_reg     <= {1'b0, d_reg[WIDTH-1:1]};
                    sd_reg    <= {1'b0, sd_reg[WIDTH-1:1]};
                    k_reg     <= k_reg - KW'(1);
                end
            end
            ST_RED: begin
                ok_reg <= (m_reg != '0) && (r_old_reg == WIDTH'(1));
                // coefficient magnitude never exceeds the modulus
                if (s_old_reg >= m_reg) begin
                    s_old_reg <= red_diff;
                end
            end
            ST_INV: begin
                res_reg.divisor    <= 32'(r_old_reg);
                res_reg.invertible <= ok_reg;
                // red_diff here is s - m; negate gives m - s
                res_reg.inverse    <= ok_reg
                    ? 32'((odd_reg && (s_old_reg != '0)) ? (m_reg - s_old_reg) : inv_val)
                    : 32'd0;
            end
            ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    assign idle     = (state_reg == ST_IDLE);
    assign done     = (state_reg == ST_DONE);
    assign res_word = res_reg;

endmodule

// File: src/modular_inverse_unit.sv
// modular inverse unit top level: handshakes and output register
`timescale 1ns / 1ps
//
// takes a word {value, modulus} on the s_ channel and returns one word
// {inverse, divisor, invertible} on the m_ channel for each input word.
// divisor is gcd(value, modulus); invertible is set when it is 1 and the
// modulus is nonzero; inverse lies in 0 .. modulus-1 and is 0 otherwise.
// the extended euclid loop runs on one shared subtract/add unit: each euclid
// step loads the divisor, doubles it once per quotient bit beyond the first,
// then subtracts once per quotient bit while halving it back. consecutive
// fibonacci operands give the most euclid steps.
// s_ready is high only while the sequencer is idle; one word is worked on at
// a time, and the next word is taken once the result moves to the output register.
// the finished word sits in an output register, so a new input word
// is taken while m_valid waits on a stalled receiver; the sequencer then
// holds its next result until the output register frees.
// aresetn (synchronous, active low) drops m_valid and returns to idle;
// nothing is kept between words.
//

module modular_inverse_unit
    import mi_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  mi_in_t  s_word,
    output logic    m_valid,
    input  logic    m_ready,
    output mi_out_t m_word
);

    logic    core_idle;
    logic    core_done;
    logic    core_take;
    mi_out_t core_res;
    logic    m_valid_reg;
    mi_out_t m_word_reg;

    mi_euclid_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (s_valid),
        .in_word  (s_word),
        .idle     (core_idle),
        .done     (core_done),
        .take     (core_take),
        .res_word (core_res)
    );

    assign s_ready   = core_idle;
    assign core_take = core_done && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (core_take) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (core_take) begin
            m_word_reg <= core_res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

endmodule

// File: src/mi_checker.sv
// port-level checker for the modular inverse unit, bound to the top level
`timescale 1ns / 1ps

module mi_checker
    import mi_pkg::*;
(
    input logic    aclk,
    input logic    aresetn,
    input logic    s_valid,
    input logic    s_ready,
    input logic    m_valid,
    input logic    m_ready,
    input mi_out_t m_word
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_word))
        else $error("result word changed while stalled");

    // one word at a time: busy right after taking a word
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while busy");

    a_flag_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_word.invertible |-> m_word.divisor == 32'd1)
        else $error("invertible flag with divisor other than one");

    a_zero_inverse: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_word.invertible |-> m_word.inverse == 32'd0)
        else $error("nonzero inverse without flag");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind modular_inverse_unit mi_checker u_mi_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_word  (m_word)
);

// File: test/modular_inverse_unit_tb.sv
// testbench for the modular inverse unit: random and directed words, scoreboard check
`timescale 1ns / 1ps

module modular_inverse_unit_tb;
    import mi_pkg::*;

    localparam int CYCLE_LIMIT = 1200000;
    localparam int DRAIN_CYCLES = 300;
    localparam int WORDS_PER_PHASE = 495;
    localparam int HOLD_CYCLES = 800;

    typedef struct {
        mi_in_t  src;
        mi_out_t want;
    } pending_t;

    class inverse_scoreboard;
        pending_t pending_results[$];
        int       failures;
        int       checked;

        function new();
            failures = 0;
            checked = 0;
        endfunction

        // extended euclid with the coefficient kept as magnitude plus step parity
        function mi_out_t inverse_of(mi_in_t w);
            longint unsigned mask, m, r_old, r_cur, s_old, s_cur, q, t;
            bit              odd;
            mi_out_t         res;
            mask = {64{1'b1}} >> (64 - WIDTH);
            m = 64'(w.modulus) & mask;
            r_old = 64'(w.value) & mask;
            r_cur = m;
            s_old = 1;
            s_cur = 0;
            odd = 1'b0;
            while (r_cur != 0) begin
                q = r_old / r_cur;
                t = r_old - q * r_cur;
                r_old = r_cur;
                r_cur = t;
                t = s_old + q * s_cur;
                s_old = s_cur;
                s_cur = t;
                odd = !odd;
            end
            res = '0;
            res.divisor = r_old[31:0];
            if (m != 0 && r_old == 1) begin
                res.invertible = 1'b1;
                t = s_old % m;
                if (odd && t != 0)
                    t = m - t;
                res.inverse = t[31:0];
            end
            return res;
        endfunction

        function void note_input(mi_in_t w);
            pending_t p;
            p.src = w;
            p.want = inverse_of(w);
            pending_results.push_back(p);
        endfunction

        function void check_result(mi_out_t got);
            pending_t p;
            checked++;
            if (pending_results.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result word: inv=%h gcd=%h ok=%b",
                             got.inverse, got.divisor, got.invertible);
                return;
            end
            p = pending_results.pop_front();
            if (got.inverse !== p.want.inverse || got.divisor !== p.want.divisor ||
                got.invertible !== p.want.invertible) begin
                failures++;
                if (failures <= 10) begin
                    $write("mismatch value=%h modulus=%h: ", p.src.value, p.src.modulus);
                    $display("want inv=%h gcd=%h ok=%b, got inv=%h gcd=%h ok=%b",
                             p.want.inverse, p.want.divisor, p.want.invertible,
                             got.inverse, got.divisor, got.invertible);
                end
            end
        endfunction
    endclass

    logic    aclk;
    logic    aresetn;
    logic    s_valid;
    logic    s_ready;
    mi_in_t  s_word;
    logic    m_valid;
    logic    m_ready;
    mi_out_t m_word;

    inverse_scoreboard sb;
    int snd_idle_pct;
    int rcv_idle_pct;
    bit hold_req;
    int hold_left;
    int words_sent;
    int cycle_count;

    modular_inverse_unit DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("Verification failed");
        $finish;
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        m_ready = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_left == 0 && hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_word);
    end

    function automatic mi_in_t pair(logic [31:0] v, logic [31:0] m);
        mi_in_t w;
        w.value = v;
        w.modulus = m;
        return w;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(mi_in_t w);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_word <= w;
        do
            @(posedge aclk);
        while (!s_ready);
        sb.note_input(w);
        words_sent++;
        @(negedge aclk);
    endtask

    function automatic mi_in_t random_word();
        logic [31:0] g, a, b;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return pair($urandom, $urandom);
            4: return pair($urandom_range(0, 300), $urandom_range(0, 300));
            5: begin
                // forced common factor
                g = $urandom_range(2, 1000);
                a = $urandom_range(0, 4000000);
                b = $urandom_range(1, 4000000);
                return pair(g * a, g * b);
            end
            6: begin
                case ($urandom_range(0, 2))
                    0: a = 32'd3;
                    1: a = 32'd17;
                    default: a = 32'd65537;
                endcase
                return pair(a, $urandom);
            end
            7: begin
                case ($urandom_range(0, 3))
                    0: a = 32'd0;
                    1: a = 32'd1;
                    2: a = 32'd2;
                    default: a = 32'hFFFF_FFFF;
                endcase
                if ($urandom_range(0, 1))
                    return pair(a, $urandom);
                return pair($urandom, a);
            end
            8: return pair($urandom, $urandom >> $urandom_range(0, 31));
            default: begin
                b = $urandom;
                return pair($urandom_range(0, 1) ? b - 1 : b + 1, b);
            end
        endcase
    endfunction

    initial begin
        sb = new();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_word = '0;
        hold_req = 1'b0;
        snd_idle_pct = 21;
        rcv_idle_pct = 45;
        words_sent = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed corners
        send_word(pair(32'd0, 32'd0));
        send_word(pair(32'd12345, 32'd0));
        send_word(pair(32'hFFFF_FFFF, 32'd0));
        send_word(pair(32'd0, 32'd1));
        send_word(pair(32'hFFFF_FFFF, 32'd1));
        send_word(pair(32'd0, 32'd5));
        send_word(pair(32'd0, 32'hFFFF_FFFF));
        send_word(pair(32'd1, 32'hFFFF_FFFF));
        send_word(pair(32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_word(pair(32'hFFFF_FFFE, 32'hFFFF_FFFF));
        send_word(pair(32'hFFFF_FFFF, 32'hFFFF_FFFE));
        send_word(pair(32'd65537, 32'd3220_000_000));
        send_word(pair(32'd6, 32'd9));
        send_word(pair(32'd10, 32'd7));
        send_word(pair(32'd7, 32'd7));
        // consecutive fibonacci numbers: most euclid steps
        send_word(pair(32'd1836311903, 32'd2971215073));
        send_word(pair(32'd2971215073, 32'd1836311903));
        send_word(pair(32'd3, 32'h8000_0000));
        send_word(pair(32'h8000_0000, 32'hFFFF_FFFF));
        send_word(pair(32'h8000_0000, 32'h8000_0000));
        send_word(pair(32'd1, 32'd2));
        send_word(pair(32'hAAAA_AAAA, 32'h5555_5555));

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    snd_idle_pct = 21;
                    rcv_idle_pct = 45;
                end
                1: begin
                    snd_idle_pct = 45;
                    rcv_idle_pct = 21;
                end
                default: begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                    // long output stall so the block backs up onto its input
                    hold_req = 1'b1;
                end
            endcase
            for (int i = 0; i < WORDS_PER_PHASE; i++)
                send_word(random_word());
        end
        s_valid <= 1'b0;

        while (sb.pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.pending_results.size() != 0) begin
            sb.failures += sb.pending_results.size();
            $display("%0d results never arrived", sb.pending_results.size());
        end
        $display("%0d words sent, %0d results checked under three stall patterns",
                 words_sent, sb.checked);
        $display("covered zero and unit operands, shared factors and a long output stall");
        if (sb.failures == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d failures", sb.failures);
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: modular_inverse_unit.f
src/mi_pkg.sv
src/mi_euclid_core.sv
src/modular_inverse_unit.sv
src/mi_checker.sv
test/modular_inverse_unit_tb.sv
